### rtl/srtf_pkg.sv
// ============================================================================
// srtf_pkg: shared definitions for the preemptive shortest-remaining-time
// scheduler. Holds field widths, result status codes and the microcode ROM.
// ============================================================================
`default_nettype none

package srtf_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W    = 4;
  localparam int BURST_W   = 16;
  localparam int TIME_W    = 24;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] STATUS_ACCEPT = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_RAN    = 2'd2;
  localparam logic [1:0] STATUS_IDLE   = 2'd3;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef logic [2:0] upc_t;

  localparam upc_t UP_WAIT  = 3'd0;
  localparam upc_t UP_ARR   = 3'd1;
  localparam upc_t UP_TICK  = 3'd2;
  localparam upc_t UP_SWEEP = 3'd3;
  localparam upc_t UP_FETCH = 3'd4;
  localparam upc_t UP_APPLY = 3'd5;

  // Sequencing condition of a control word.
  typedef enum logic [2:0] {
    C_NEXT,   // fall through to the next step
    C_GOTO,   // jump to the target
    C_IN_OP,  // hold until a word is taken, then tick jumps, arrival falls through
    C_SWEEP,  // hold until the slot sweep reaches its last slot
    C_EMIT    // hold until the result register is free, then jump
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    logic  arr_do;
    logic  tick_init;
    logic  sweep_en;
    logic  fetch_en;
    logic  apply_en;
    cond_e cond;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{in_rdy: 1'b0, arr_do: 1'b0, tick_init: 1'b0, sweep_en: 1'b0,
          fetch_en: 1'b0, apply_en: 1'b0, cond: C_GOTO, target: UP_WAIT};
    unique case (a)
      UP_WAIT: begin
        w.in_rdy = 1'b1;
        w.cond   = C_IN_OP;
        w.target = UP_TICK;
      end
      UP_ARR: begin
        w.arr_do = 1'b1;
        w.cond   = C_EMIT;
        w.target = UP_WAIT;
      end
      UP_TICK: begin
        w.tick_init = 1'b1;
        w.cond      = C_NEXT;
      end
      UP_SWEEP: begin
        w.sweep_en = 1'b1;
        w.cond     = C_SWEEP;
      end
      UP_FETCH: begin
        w.fetch_en = 1'b1;
        w.cond     = C_NEXT;
      end
      UP_APPLY: begin
        w.apply_en = 1'b1;
        w.cond     = C_EMIT;
        w.target   = UP_WAIT;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = UP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/srtf_preemptive_scheduler.sv
// ============================================================================
// srtf_preemptive_scheduler: preemptive shortest-remaining-time-first job
// scheduler over a table of job slots, driven by a microcoded sequencer.
// ============================================================================
// An arrival word goes from acceptance through the arrival step to its result; a tick
// word goes through the tick, sweep, fetch and apply steps, the sweep reading one table
// slot per cycle. A new word is taken only after the previous result has entered the
// output register, and may be taken while that result still waits there.
// Reset (rst_ni low, asynchronous) empties the slot table, clears the tick counter and
// the current job; the job tables themselves are not cleared.
`default_nettype none

module srtf_preemptive_scheduler #(
  parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              operation_i,
  input  wire  [srtf_pkg::SLOT_W-1:0]      slot_i,
  input  wire  [srtf_pkg::BURST_W-1:0]     burst_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [1:0]                       status_o,
  output logic [srtf_pkg::SLOT_W-1:0]      running_slot_o,
  output logic                             finished_o,
  output logic [srtf_pkg::TIME_W-1:0]      wait_time_o,
  output logic [srtf_pkg::TIME_W-1:0]      turnaround_time_o,
  output logic [srtf_pkg::TIME_W-1:0]      finish_time_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [srtf_pkg::BURST_W-1:0] burst_t;
  typedef logic [srtf_pkg::TIME_W-1:0]  time_t;

  // Job tables: remaining time, original burst and accumulated wait per slot.
  // Each has one write port and one registered read port sharing rd_addr.
  burst_t rem_mem   [SLOTS];
  burst_t burst_mem [SLOTS];
  time_t  wait_mem  [SLOTS];
  burst_t rem_rd_q;
  burst_t burst_rd_q;
  time_t  wait_rd_q;

  // Sequencer and scheduler control state.
  srtf_pkg::upc_t upc_q, upc_d;
  logic           out_valid_q;
  logic [SLOTS-1:0] active_q, active_d;
  idx_t           cur_slot_q;
  logic           cur_valid_q;
  logic           pending_q;
  time_t          tick_q;
  idx_t           cnt_q;
  logic           sel_q;
  logic           found_q;

  // Latched input word and the candidate picked during a sweep.
  logic                       op_q;
  logic [srtf_pkg::SLOT_W-1:0] slot_q;
  burst_t                     burst_q;
  idx_t                       best_slot_q;
  burst_t                     best_rem_q;
  time_t                      best_wait_q;

  // Result register.
  logic [1:0]                  status_q;
  logic [srtf_pkg::SLOT_W-1:0] run_slot_q;
  logic                        fin_q;
  time_t                       wait_q;
  time_t                       tat_q;
  time_t                       ftime_q;

  srtf_pkg::uword_t uw;
  logic   in_acc;
  logic   emit_ok;
  logic   sw_act;
  logic   sw_better;
  time_t  wait_inc;
  logic   run_ok;
  burst_t rem_dec;
  logic   fin;
  idx_t   arr_idx;
  logic   arr_ok;
  logic [srtf_pkg::TIME_W:0] tat_sum;
  time_t  tat_sat;
  idx_t   rd_addr;
  idx_t   wr_addr;
  logic   rem_we;
  logic   burst_we;
  logic   wait_we;
  burst_t rem_wd;
  time_t  wait_wd;

  always_comb begin
    uw      = srtf_pkg::ucode(upc_q);
    in_acc  = uw.in_rdy && in_valid_i;
    // The result register can take a new word when empty or being drained.
    emit_ok = !out_valid_q || out_ready_i;

    // During a sweep, the read data belongs to slot cnt_q.
    sw_act    = active_q[cnt_q];
    sw_better = !found_q || (rem_rd_q < best_rem_q);
    wait_inc  = (wait_rd_q == srtf_pkg::TIME_MAX) ? wait_rd_q : time_t'(wait_rd_q + 1'b1);

    run_ok  = cur_valid_q && active_q[cur_slot_q];
    rem_dec = burst_t'(best_rem_q - 1'b1);
    fin     = run_ok && (rem_dec == '0);
    tat_sum = {1'b0, best_wait_q} + (srtf_pkg::TIME_W + 1)'(burst_rd_q);
    tat_sat = tat_sum[srtf_pkg::TIME_W] ? srtf_pkg::TIME_MAX
                                         : tat_sum[srtf_pkg::TIME_W-1:0];

    arr_idx = idx_t'(slot_q);
    arr_ok  = (32'(slot_q) < SLOTS) && !active_q[arr_idx] && (burst_q != '0);

    // Read address: slot 0 ahead of the sweep, the next slot during it, and
    // the running slot afterwards so its burst stays on the read register.
    priority if (uw.tick_init) begin
      rd_addr = '0;
    end else if (uw.sweep_en) begin
      rd_addr = idx_t'(cnt_q + 1'b1);
    end else if (uw.fetch_en) begin
      rd_addr = sel_q ? best_slot_q : cur_slot_q;
    end else begin
      rd_addr = cur_slot_q;
    end

    wr_addr  = cur_slot_q;
    rem_we   = 1'b0;
    burst_we = 1'b0;
    wait_we  = 1'b0;
    rem_wd   = rem_dec;
    wait_wd  = best_wait_q;
    if (uw.arr_do && emit_ok && arr_ok) begin
      wr_addr  = arr_idx;
      rem_we   = 1'b1;
      burst_we = 1'b1;
      wait_we  = 1'b1;
      rem_wd   = burst_q;
      wait_wd  = '0;
    end else if (uw.sweep_en && sw_act && (sel_q || (cnt_q != cur_slot_q))) begin
      // While picking, every active job is charged a wait unit here, otherwise every active
      // job but the current one; the winner's original wait is written back when it is applied.
      wr_addr = cnt_q;
      wait_we = 1'b1;
      wait_wd = wait_inc;
    end else if (uw.apply_en && emit_ok && run_ok) begin
      rem_we  = 1'b1;
      wait_we = 1'b1;
    end

    active_d = active_q;
    if (uw.arr_do && emit_ok && arr_ok) begin
      active_d[arr_idx] = 1'b1;
    end else if (uw.apply_en && emit_ok && fin) begin
      active_d[cur_slot_q] = 1'b0;
    end

    unique case (uw.cond)
      srtf_pkg::C_NEXT:  upc_d = srtf_pkg::upc_t'(upc_q + 1'b1);
      srtf_pkg::C_GOTO:  upc_d = uw.target;
      srtf_pkg::C_IN_OP: begin
        if (!in_acc) begin
          upc_d = upc_q;
        end else if (operation_i == srtf_pkg::OP_TICK) begin
          upc_d = uw.target;
        end else begin
          upc_d = srtf_pkg::upc_t'(upc_q + 1'b1);
        end
      end
      srtf_pkg::C_SWEEP: upc_d = (cnt_q == LAST_IDX) ? srtf_pkg::upc_t'(upc_q + 1'b1) : upc_q;
      srtf_pkg::C_EMIT:  upc_d = emit_ok ? uw.target : upc_q;
      default:           upc_d = uw.target;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wd;
    end
    if (burst_we) begin
      burst_mem[wr_addr] <= burst_q;
    end
    if (wait_we) begin
      wait_mem[wr_addr] <= wait_wd;
    end
    rem_rd_q   <= rem_mem[rd_addr];
    burst_rd_q <= burst_mem[rd_addr];
    wait_rd_q  <= wait_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= srtf_pkg::UP_WAIT;
      out_valid_q <= 1'b0;
      active_q    <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      pending_q   <= 1'b0;
      tick_q      <= '0;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      upc_q    <= upc_d;
      active_q <= active_d;
      // A new result word fills the register; otherwise a taken word empties it.
      if ((uw.arr_do || uw.apply_en) && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (uw.arr_do && emit_ok && arr_ok) begin
        pending_q <= 1'b1;
      end
      if (uw.tick_init) begin
        tick_q  <= time_t'(tick_q + 1'b1);
        cnt_q   <= '0;
        found_q <= 1'b0;
        // A new pick is made after any accepted arrival or when no job is current.
        sel_q   <= pending_q || !cur_valid_q;
        if (pending_q || !cur_valid_q) begin
          pending_q <= 1'b0;
        end
      end
      if (uw.sweep_en) begin
        cnt_q <= idx_t'(cnt_q + 1'b1);
        if (sel_q && sw_act && sw_better) begin
          found_q <= 1'b1;
        end
      end
      if (uw.fetch_en && sel_q) begin
        cur_slot_q  <= best_slot_q;
        cur_valid_q <= found_q;
      end
      if (uw.apply_en && emit_ok) begin
        if (!run_ok || fin) begin
          cur_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      slot_q  <= slot_i;
      burst_q <= burst_i;
    end
    if (uw.sweep_en) begin
      if (sel_q) begin
        if (sw_act && sw_better) begin
          best_slot_q <= cnt_q;
          best_rem_q  <= rem_rd_q;
          best_wait_q <= wait_rd_q;
        end
      end else if (cnt_q == cur_slot_q) begin
        best_rem_q  <= rem_rd_q;
        best_wait_q <= wait_rd_q;
      end
    end
    if (uw.arr_do && emit_ok) begin
      status_q   <= (arr_ok && (op_q == srtf_pkg::OP_ARRIVE)) ? srtf_pkg::STATUS_ACCEPT
                                                              : srtf_pkg::STATUS_REJECT;
      run_slot_q <= '0;
      fin_q      <= 1'b0;
      wait_q     <= '0;
      tat_q      <= '0;
      ftime_q    <= '0;
    end
    if (uw.apply_en && emit_ok) begin
      status_q   <= run_ok ? srtf_pkg::STATUS_RAN : srtf_pkg::STATUS_IDLE;
      run_slot_q <= run_ok ? (srtf_pkg::SLOT_W)'(cur_slot_q) : '0;
      fin_q      <= fin;
      wait_q     <= fin ? best_wait_q : '0;
      tat_q      <= fin ? tat_sat : '0;
      ftime_q    <= fin ? tick_q : '0;
    end
  end

  assign in_ready_o        = uw.in_rdy;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign running_slot_o    = run_slot_q;
  assign finished_o        = fin_q;
  assign wait_time_o       = wait_q;
  assign turnaround_time_o = tat_q;
  assign finish_time_o     = ftime_q;

endmodule

`default_nettype wire

### rtl/srtf_chk.sv
// ============================================================================
// srtf_chk: port-level checks for the shortest-remaining-time scheduler.
// Watches the result channel for handshake stability and field consistency.
// ============================================================================
`default_nettype none

module srtf_chk (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire [1:0]                    status_o,
  input wire [srtf_pkg::SLOT_W-1:0]   running_slot_o,
  input wire                          finished_o,
  input wire [srtf_pkg::TIME_W-1:0]   wait_time_o,
  input wire [srtf_pkg::TIME_W-1:0]   turnaround_time_o
);

  // A stalled result word stays valid with its status, finish flag and wait held.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(finished_o) && $stable(wait_time_o))
    else $error("result word changed while stalled");

  // Only a tick that ran a job can report a completion.
  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> status_o == srtf_pkg::STATUS_RAN)
    else $error("completion reported without a running job");

  // Words that ran nothing carry no slot.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != srtf_pkg::STATUS_RAN |-> running_slot_o == '0)
    else $error("slot reported on a word that ran no job");

  // Turnaround covers at least the wait.
  a_tat_ge_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> turnaround_time_o >= wait_time_o)
    else $error("turnaround below wait");

endmodule

bind srtf_preemptive_scheduler srtf_chk u_srtf_chk (.*);

`default_nettype wire
